// ===== rtl/bfwa_pkg.sv =====
// Shared types and constants for the box filter window average block.
// No dependencies.
package bfwa_pkg;

  localparam logic FMT_RGB888   = 1'b0;
  localparam logic FMT_ARGB4444 = 1'b1;

  localparam int QuotW = 9;

  typedef struct packed {
    logic [23:0] source_pixel;
    logic        window_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] average_pixel;
    logic        window_overflow;
  } out_item_t;

  typedef struct packed {
    logic overflow;
    logic pixel_format;
  } win_flags_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_e;

endpackage

// ===== rtl/box_filter_window_average.sv =====
// A window's result comes after its last pixel is accepted: the record is
// queued, divided, then registered at the output once the output is free.
// Throughput: one pixel per cycle while the queue is not full; the divider
// finds 9 quotient bits per window, and a 2-entry queue holds finished windows.
// Reset clears the sums, count and queue, sets pixel_format to RGB.
module box_filter_window_average
  import bfwa_pkg::*;
#(
  parameter int MAX_STEP = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int MaxArea = MAX_STEP * MAX_STEP;
  localparam int CntW    = $clog2(MaxArea + 1);
  localparam int SumW    = $clog2(255 * MaxArea + 1);
  localparam int RecW    = 4 * SumW + CntW + $bits(win_flags_t);

  logic                 push;
  logic                 pop;
  logic                 fifo_full;
  logic                 fifo_empty;
  logic [3:0][SumW-1:0] f_sums, b_sums;
  logic [CntW-1:0]      f_count, b_count;
  win_flags_t           f_flags, b_flags;
  logic [RecW-1:0]      wrec, rrec;

  assign wrec = {f_sums, f_count, f_flags};
  assign {b_sums, b_count, b_flags} = rrec;

  bfwa_front #(
    .MaxStep(MAX_STEP)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .fifo_full_i(fifo_full),
    .push_o     (push),
    .sums_o     (f_sums),
    .count_o    (f_count),
    .flags_o    (f_flags)
  );

  bfwa_fifo #(
    .Width(RecW)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .wdata_i(wrec),
    .pop_i  (pop),
    .rdata_o(rrec),
    .full_o (fifo_full),
    .empty_o(fifo_empty)
  );

  bfwa_back #(
    .MaxStep(MAX_STEP)
  ) u_back (
    .clk_i,
    .rst_ni,
    .fifo_empty_i(fifo_empty),
    .pop_o       (pop),
    .sums_i      (b_sums),
    .count_i     (b_count),
    .flags_i     (b_flags),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule

// ===== rtl/bfwa_fifo.sv =====
// Two-entry queue of finished window records between front and back.
// Depends on nothing but its width parameter.
module bfwa_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [1:0][Width-1:0] mem_q;
  logic                  wr_ptr_q, wr_ptr_d;
  logic                  rd_ptr_q, rd_ptr_d;
  logic [1:0]            count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("queue push while full");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o)
    else $error("queue empty after push");
`endif

endmodule

// ===== rtl/bfwa_front.sv =====
// Front end: pixel format register, channel split and window accumulation.
// Pushes one record per window into the queue. Uses bfwa_pkg.
module bfwa_front
  import bfwa_pkg::*;
#(
  parameter int MaxStep = 16,
  parameter int MaxArea = MaxStep * MaxStep,
  parameter int CntW    = $clog2(MaxArea + 1),
  parameter int SumW    = $clog2(255 * MaxArea + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  input  logic                 fifo_full_i,
  output logic                 push_o,
  output logic [3:0][SumW-1:0] sums_o,
  output logic [CntW-1:0]      count_o,
  output win_flags_t           flags_o
);

  logic                 fmt_q;
  logic [3:0][SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [3:0][7:0]      chan;
  logic [3:0][SumW-1:0] sum_inc;
  logic                 area_full;
  logic                 accept;
  logic [23:0]          px;

  assign px         = in_data_i.source_pixel;
  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && in_data_i.window_last;
  assign area_full  = (cnt_q == CntW'(MaxArea));

  always_comb begin
    if (fmt_q == FMT_RGB888) begin
      chan[0] = px[7:0];
      chan[1] = px[15:8];
      chan[2] = px[23:16];
      chan[3] = 8'hFF;
    end else begin
      chan[0] = {4'h0, px[3:0]};
      chan[1] = {4'h0, px[7:4]};
      chan[2] = {4'h0, px[11:8]};
      chan[3] = {4'h0, px[15:12]};
    end
    for (int i = 0; i < 4; i++) begin
      sum_inc[i] = sum_q[i] + SumW'(chan[i]);
    end
  end

  always_comb begin
    sums_o  = area_full ? sum_q : sum_inc;
    count_o = area_full ? cnt_q : cnt_q + CntW'(1);
    flags_o.overflow     = ovf_q || area_full;
    flags_o.pixel_format = fmt_q;
  end

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (in_data_i.window_last) begin
        sum_d = '0;
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        sum_d = sums_o;
        cnt_d = count_o;
        ovf_d = flags_o.overflow;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RGB888;
      sum_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

// ===== rtl/bfwa_back.sv =====
// Back end: rounded average of four channel sums by a shared-schedule
// restoring divider (one quotient bit per cycle), then packing and the
// output register. Uses bfwa_pkg.
module bfwa_back
  import bfwa_pkg::*;
#(
  parameter int MaxStep = 16,
  parameter int MaxArea = MaxStep * MaxStep,
  parameter int CntW    = $clog2(MaxArea + 1),
  parameter int SumW    = $clog2(255 * MaxArea + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fifo_empty_i,
  output logic                 pop_o,
  input  logic [3:0][SumW-1:0] sums_i,
  input  logic [CntW-1:0]      count_i,
  input  win_flags_t           flags_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);

  localparam int RemW = SumW + 2;
  localparam int DvW  = CntW + QuotW;
  localparam int CmpW = (DvW > RemW) ? DvW : RemW;

  back_state_e          state_q, state_d;
  logic [3:0][RemW-1:0] rem_q, rem_d;
  logic [3:0][QuotW-1:0] quo_q, quo_d;
  logic [DvW-1:0]       dv_q, dv_d;
  logic [3:0]           step_q, step_d;
  win_flags_t           flags_q;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_data_q;
  out_item_t            packed_res;
  logic                 load_div;
  logic                 div_step;
  logic                 load_out;
  logic [3:0][QuotW-1:0] avg;
  logic [QuotW-1:0]     top;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!fifo_empty_i) begin
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step_q == 4'd0) begin
          state_d = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    load_div = 1'b0;
    div_step = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: load_div = !fifo_empty_i;
      BK_DIV:  div_step = 1'b1;
      BK_HOLD: load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign pop_o = load_div;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dv_d   = dv_q;
    step_d = step_q;
    if (load_div) begin
      for (int i = 0; i < 4; i++) begin
        rem_d[i] = (RemW'(sums_i[i]) << 1) + RemW'(count_i);
        quo_d[i] = '0;
      end
      dv_d   = DvW'(count_i) << QuotW;
      step_d = 4'(QuotW - 1);
    end else if (div_step) begin
      for (int i = 0; i < 4; i++) begin
        if (CmpW'(rem_q[i]) >= CmpW'(dv_q)) begin
          rem_d[i] = RemW'(CmpW'(rem_q[i]) - CmpW'(dv_q));
          quo_d[i] = {quo_q[i][QuotW-2:0], 1'b1};
        end else begin
          quo_d[i] = {quo_q[i][QuotW-2:0], 1'b0};
        end
      end
      dv_d   = dv_q >> 1;
      step_d = step_q - 4'd1;
    end
  end

  always_comb begin
    top = (flags_q.pixel_format == FMT_RGB888) ? QuotW'(255) : QuotW'(15);
    for (int i = 0; i < 4; i++) begin
      avg[i] = (quo_q[i] > top) ? top : quo_q[i];
    end
    if (flags_q.pixel_format == FMT_RGB888) begin
      packed_res.average_pixel = {8'hFF, avg[0][7:0], avg[1][7:0], avg[2][7:0]};
    end else begin
      packed_res.average_pixel = {16'h0000, avg[3][3:0], avg[0][3:0],
                                  avg[1][3:0], avg[2][3:0]};
    end
    packed_res.window_overflow = flags_q.overflow;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dv_q  <= dv_d;
    if (load_div) begin
      flags_q <= flags_i;
    end
    if (load_out) begin
      out_data_q <= packed_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
